// ----- rtl/rlw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the RTP loss window tracker.
// No dependencies; every other file imports this package.
package rlw_pkg;

  localparam int unsigned SEQ_W          = 32;
  localparam int unsigned ARR_W          = 32;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch a new item
    logic rd_pos;     // read the missing flag of the item's own slot
    logic rd_gap;     // read the missing flag of the next skipped slot
    logic hold_pos;   // keep the own-slot flag while the gap is filled
    logic wr_pos;     // write the item's own slot and issue the result
    logic rel_now;    // release using the flag just read
    logic rel_saved;  // release using the kept own-slot flag
    logic set_ne;     // advance next expected past the item
    logic wr_gap;     // mark one skipped slot missing
    logic sweep;      // clear one slot of the window
  } rlw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic big_jump;
    logic win_empty;
    logic ahead;
    logic ne_eq_seq;
    logic gap_last;
    logic sweep_last;
  } rlw_stat_t;

  function automatic logic is_pow2(input int unsigned d);
    return (d & (d - 1)) == 0;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_dec(input logic [COUNT_W-1:0] c);
    return (c == '0) ? c : c - COUNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

// ----- rtl/rtp_loss_window_tracker_top.sv -----
`timescale 1ns / 1ps
// Top level of the RTP loss window tracker: controller plus datapath.
// Uses rlw_pkg, rlw_ctrl and rlw_datapath.

// Each item is one received packet (ext_seq_i, arrival_ms_i), taken when start is high
// and busy is low; one result, the running count of missing packets in the window,
// appears on lost_count_o for exactly one cycle with lost_count_valid_o high and
// cannot be held off. The window keeps one missing flag per slot in a single memory
// with one write and one registered read per cycle, and that port sets the timing.
// With a power-of-two RING_DEPTH an in-order, late, duplicate or first packet goes
// through S_EXEC alone; a packet that skips sequence numbers also marks one skipped
// slot per S_GAP step; a jump of RING_DEPTH-1 or more clears the window in S_CLR.
// Other depths first pass S_WAIT and S_RDPOS for the ring index multiply pipeline.
// After reset a clearing pass over every slot runs with busy high.
module rtp_loss_window_tracker_top #(
  parameter int unsigned RING_DEPTH = rlw_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [rlw_pkg::SEQ_W-1:0]    ext_seq_i,
  input  logic [rlw_pkg::ARR_W-1:0]    arrival_ms_i,
  output logic [rlw_pkg::COUNT_W-1:0]  lost_count_o,
  output logic                         lost_count_valid_o
);
  import rlw_pkg::*;

  rlw_cmd_t  cmd;
  rlw_stat_t stat;

  rlw_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  rlw_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .ext_seq_i    (ext_seq_i),
    .arrival_ms_i (arrival_ms_i),
    .lost_count_o (lost_count_o),
    .valid_o      (lost_count_valid_o)
  );

  a_one_result_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_count_valid_o |=> !lost_count_valid_o)
    else $error("result strobe held for more than one cycle");

  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !lost_count_valid_o)
    else $error("result issued in the cycle after an item was taken");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_count_valid_o |-> !busy)
    else $error("result issued while the controller is still busy");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_count_valid_o |-> $past(busy))
    else $error("result issued without preceding work");

endmodule

// ----- rtl/rlw_ring_mod.sv -----
`timescale 1ns / 1ps
// Ring index unit: sequence number modulo the ring depth.
// Uses rlw_pkg. Power-of-two depths take a mask, others a two-stage reciprocal multiply.
module rlw_ring_mod #(
  parameter int unsigned RING_DEPTH = rlw_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic [rlw_pkg::SEQ_W-1:0]      x_i,
  output logic [$clog2(RING_DEPTH)-1:0]  idx_o
);
  import rlw_pkg::*;

  localparam int unsigned IW = $clog2(RING_DEPTH);

  if (is_pow2(RING_DEPTH)) begin : g_mask
    assign idx_o = x_i[IW-1:0];
  end else begin : g_recip
    // m = ceil(2^(32+IW) / depth) gives an exact quotient for every 32-bit value
    localparam int unsigned SH   = SEQ_W + IW;
    localparam int unsigned RW   = SEQ_W + 1;
    localparam int unsigned PW   = SEQ_W + RW;
    localparam logic [63:0] RECIP =
      ((64'd1 << SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);

    logic [PW-1:0]    prod_q;
    logic [SEQ_W-1:0] x1_q;
    logic [SEQ_W-1:0] x2_q;
    logic [SEQ_W-1:0] qd_q;
    logic [SEQ_W-1:0] quo_w;
    logic [SEQ_W-1:0] rem_w;

    assign quo_w = SEQ_W'(prod_q >> SH);
    assign rem_w = x2_q - qd_q;
    assign idx_o = rem_w[IW-1:0];

    always_ff @(posedge clk_i) begin
      prod_q <= PW'(x_i) * PW'(RECIP[RW-1:0]);
      x1_q   <= x_i;
      qd_q   <= quo_w * SEQ_W'(RING_DEPTH);
      x2_q   <= x1_q;
    end
  end

endmodule

// ----- rtl/rlw_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the loss window tracker: missing-flag ring, next expected, loss count.
// Uses rlw_pkg and rlw_ring_mod; driven by commands from rlw_ctrl.
module rlw_datapath #(
  parameter int unsigned RING_DEPTH = rlw_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rlw_pkg::rlw_cmd_t            cmd_i,
  output rlw_pkg::rlw_stat_t           stat_o,
  input  logic [rlw_pkg::SEQ_W-1:0]    ext_seq_i,
  input  logic [rlw_pkg::ARR_W-1:0]    arrival_ms_i,
  output logic [rlw_pkg::COUNT_W-1:0]  lost_count_o,
  output logic                         valid_o
);
  import rlw_pkg::*;

  localparam int unsigned      IW       = $clog2(RING_DEPTH);
  localparam logic [IW-1:0]    IDX_LAST = IW'(RING_DEPTH - 1);
  localparam logic [SEQ_W-1:0] JUMP_MIN = SEQ_W'(RING_DEPTH - 1);
  localparam logic             IS_POW2  = is_pow2(RING_DEPTH);

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IW'(1);
  endfunction

  // Only the missing status of a slot (valid and no arrival time) affects the count
  logic miss_mem [RING_DEPTH];

  logic [SEQ_W-1:0]   seq_q;
  logic               arr_zero_q;
  logic [IW-1:0]      pos_q;
  logic               rd_q;
  logic               pos_miss_q;
  logic [SEQ_W-1:0]   ne_q, ne_d;
  logic [IW-1:0]      ne_idx_q, ne_idx_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [IW-1:0]      sweep_idx_q, sweep_idx_d;
  logic               valid_q;

  logic [SEQ_W-1:0]   mod_x;
  logic [IW-1:0]      pos_w;
  logic [SEQ_W-1:0]   ne_inc;
  logic               rel;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               wr_bit;

  assign mod_x = IS_POW2 ? ext_seq_i : seq_q;

  rlw_ring_mod #(
    .RING_DEPTH (RING_DEPTH)
  ) u_mod (
    .clk_i (clk_i),
    .x_i   (mod_x),
    .idx_o (pos_w)
  );

  assign ne_inc = ne_q + SEQ_W'(1);

  always_comb begin
    stat_o.big_jump   = (seq_q > ne_q) && ((seq_q - ne_q) >= JUMP_MIN);
    stat_o.win_empty  = (ne_q == '0);
    stat_o.ahead      = (ne_q < seq_q);
    stat_o.ne_eq_seq  = (ne_q == seq_q);
    stat_o.gap_last   = (ne_inc == seq_q);
    stat_o.sweep_last = (sweep_idx_q == IDX_LAST);
  end

  assign rel = (cmd_i.rel_now & rd_q) | (cmd_i.rel_saved & pos_miss_q);

  always_comb begin
    ne_d        = ne_q;
    ne_idx_d    = ne_idx_q;
    cnt_d       = cnt_q;
    sweep_idx_d = sweep_idx_q;
    priority if (cmd_i.sweep) begin
      ne_d        = '0;
      ne_idx_d    = '0;
      cnt_d       = '0;
      sweep_idx_d = inc_idx(sweep_idx_q);
    end else if (cmd_i.wr_gap) begin
      ne_d     = ne_inc;
      ne_idx_d = inc_idx(ne_idx_q);
      cnt_d    = sat_inc(rd_q ? sat_dec(cnt_q) : cnt_q);
    end else if (cmd_i.wr_pos) begin
      if (rel) begin
        cnt_d = sat_dec(cnt_q);
      end
      if (cmd_i.set_ne) begin
        ne_d     = seq_q + SEQ_W'(1);
        ne_idx_d = inc_idx(pos_q);
      end
    end else begin
      ne_d = ne_q;
    end
  end

  // One write and one read per cycle; gap fill writes one slot while reading the next
  always_comb begin
    rd_en   = cmd_i.rd_pos | cmd_i.rd_gap;
    rd_addr = cmd_i.rd_gap ? ne_idx_d : pos_w;
    wr_en   = cmd_i.sweep | cmd_i.wr_gap | cmd_i.wr_pos;
    priority if (cmd_i.sweep) begin
      wr_addr = sweep_idx_q;
      wr_bit  = 1'b0;
    end else if (cmd_i.wr_gap) begin
      wr_addr = ne_idx_q;
      wr_bit  = 1'b1;
    end else begin
      wr_addr = pos_q;
      wr_bit  = arr_zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      miss_mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_q <= miss_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seq_q      <= ext_seq_i;
      arr_zero_q <= (arrival_ms_i == '0);
    end
    if (cmd_i.rd_pos) begin
      pos_q <= pos_w;
    end
    if (cmd_i.hold_pos) begin
      pos_miss_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q        <= '0;
      ne_idx_q    <= '0;
      cnt_q       <= '0;
      sweep_idx_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      ne_q        <= ne_d;
      ne_idx_q    <= ne_idx_d;
      cnt_q       <= cnt_d;
      sweep_idx_q <= sweep_idx_d;
      valid_q     <= cmd_i.wr_pos;
    end
  end

  assign lost_count_o = cnt_q;
  assign valid_o      = valid_q;

endmodule

// ----- rtl/rlw_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the loss window tracker: sequences clear sweeps, gap fill and slot updates.
// Uses rlw_pkg; drives rlw_datapath through command and status structs.
module rlw_ctrl #(
  parameter int unsigned RING_DEPTH = rlw_pkg::RING_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  rlw_pkg::rlw_stat_t  stat_i,
  output rlw_pkg::rlw_cmd_t   cmd_o
);
  import rlw_pkg::*;

  localparam logic IS_POW2 = is_pow2(RING_DEPTH);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_RDPOS = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_GAP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_CLR   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       wait_q, wait_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    wait_d  = wait_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (IS_POW2) begin
            cmd_o.rd_pos = 1'b1;
            state_d      = S_EXEC;
          end else begin
            wait_d  = 1'b0;
            state_d = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // wait for the ring index pipeline
        wait_d = ~wait_q;
        if (wait_q) begin
          state_d = S_RDPOS;
        end
      end
      S_RDPOS: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        priority if (stat_i.big_jump) begin
          state_d = S_CLR;
        end else if (stat_i.win_empty) begin
          cmd_o.wr_pos = 1'b1;
          cmd_o.set_ne = 1'b1;
          state_d      = S_IDLE;
        end else if (stat_i.ahead) begin
          cmd_o.hold_pos = 1'b1;
          cmd_o.rd_gap   = 1'b1;
          state_d        = S_GAP;
        end else begin
          cmd_o.wr_pos  = 1'b1;
          cmd_o.rel_now = 1'b1;
          cmd_o.set_ne  = stat_i.ne_eq_seq;
          state_d       = S_IDLE;
        end
      end
      S_GAP: begin
        cmd_o.wr_gap = 1'b1;
        if (stat_i.gap_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_gap = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.wr_pos    = 1'b1;
        cmd_o.rel_saved = 1'b1;
        cmd_o.set_ne    = 1'b1;
        state_d         = S_IDLE;
      end
      S_CLR: begin
        // after the sweep the item is taken as the first of a fresh window
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_FIN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
